### rtl/bhtq_pkg.sv
// Shared types, sizes and codes for the binary heap timer queue.
// Used by the core, the heap RAM and the port checker; depends on nothing.
package bhtq_pkg;

  localparam int CAPACITY  = 32;
  localparam int ID_COUNT  = 256;
  localparam int TIME_BITS = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KID_W = IDX_W + 2;
  localparam int ID_W  = $clog2(ID_COUNT);
  localparam int TID_W = 8;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_FIRED     = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [TID_W-1:0]     ident;
  } entry_t;

endpackage

### rtl/bhtq_heap_ram.sv
// Heap storage: one write port, two registered read ports.
// Depends on bhtq_pkg for the entry type and depth.
module bhtq_heap_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [bhtq_pkg::IDX_W-1:0]   wr_addr,
  input  bhtq_pkg::entry_t             wr_data,
  input  logic [bhtq_pkg::IDX_W-1:0]   rd_addr_a,
  input  logic [bhtq_pkg::IDX_W-1:0]   rd_addr_b,
  output bhtq_pkg::entry_t             rd_data_a,
  output bhtq_pkg::entry_t             rd_data_b
);

  bhtq_pkg::entry_t mem [bhtq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### rtl/binary_heap_timer_queue_core.sv
// Timer queue core: min-heap of expiry times with lazy cancellation.
// Depends on bhtq_pkg and bhtq_heap_ram.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  request   | start & !busy         | mode, timer_id, expire_time, now_time
//  result    | valid (one cycle)     | kind, fired_id, fired_expire,
//            |                       | entry_count, last
//
// Cancel and rejected add: result in the cycle after the request, no busy time.
// Add: per level moved up, a parent read (ST_UP_RD) and a compare-and-write
// (ST_UP_CMP), then ST_RESP; the read state exists as heap RAM reads are registered.
// Tick: ST_TK_CHK checks the root; a pop reads the last entry in ST_DN_LAST, then
// ST_DN_RD and ST_DN_CMP per level moved down. Reset: synchronous,
// then all 256 cancel bits are cleared with busy high. Results cannot be stalled.
module binary_heap_timer_queue_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       mode,
  input  logic [bhtq_pkg::TID_W-1:0]       timer_id,
  input  logic [bhtq_pkg::TIME_BITS-1:0]   expire_time,
  input  logic [bhtq_pkg::TIME_BITS-1:0]   now_time,
  output logic                             valid,
  output logic [2:0]                       kind,
  output logic [bhtq_pkg::TID_W-1:0]       fired_id,
  output logic [bhtq_pkg::TIME_BITS-1:0]   fired_expire,
  output logic [bhtq_pkg::CNT_W-1:0]       entry_count,
  output logic                             last
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b0_0000_0001,
    ST_UP_RD   = 9'b0_0000_0010,
    ST_UP_CMP  = 9'b0_0000_0100,
    ST_RESP    = 9'b0_0000_1000,
    ST_TK_CHK  = 9'b0_0001_0000,
    ST_DN_LAST = 9'b0_0010_0000,
    ST_DN_RD   = 9'b0_0100_0000,
    ST_DN_CMP  = 9'b0_1000_0000,
    ST_CLEAR   = 9'b1_0000_0000
  } state_t;

  state_t state, state_next;

  logic [bhtq_pkg::CNT_W-1:0]     count;
  logic [bhtq_pkg::IDX_W-1:0]     hole;
  logic [bhtq_pkg::IDX_W-1:0]     pos;
  logic [bhtq_pkg::KID_W-1:0]     kid;
  logic [bhtq_pkg::TIME_BITS-1:0] now_r;
  logic [bhtq_pkg::ID_W-1:0]      clr_idx;
  logic                           cancel_mem [bhtq_pkg::ID_COUNT];
  logic                           root_cancelled;
  bhtq_pkg::entry_t               new_ent;
  bhtq_pkg::entry_t               te;
  bhtq_pkg::entry_t               root_ent;

  logic                           wr_en;
  logic [bhtq_pkg::IDX_W-1:0]     wr_addr;
  bhtq_pkg::entry_t               wr_data;
  logic [bhtq_pkg::IDX_W-1:0]     rd_addr_a;
  logic [bhtq_pkg::IDX_W-1:0]     rd_addr_b;
  bhtq_pkg::entry_t               rd_a;
  bhtq_pkg::entry_t               rd_b;

  logic                           cxl_we;
  logic [bhtq_pkg::ID_W-1:0]      cxl_waddr;
  logic                           cxl_wdata;
  logic [bhtq_pkg::ID_W-1:0]      cxl_raddr;

  logic                           accept;
  logic [bhtq_pkg::TIME_BITS-1:0] root_expiry;
  logic [bhtq_pkg::IDX_W-1:0]     parent;
  logic [bhtq_pkg::KID_W-1:0]     kid_plus;
  logic                           kid_in;
  logic                           pick_right;
  bhtq_pkg::entry_t               child;
  logic [bhtq_pkg::IDX_W-1:0]     child_idx;
  logic                           child_gt;
  logic                           pop_now;
  logic [bhtq_pkg::CNT_W-1:0]     count_dec;

  bhtq_heap_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign root_expiry = (count != '0) ? root_ent.expiry : '0;
  assign parent      = (hole - 1'b1) >> 1;
  assign kid_plus    = kid + 1'b1;
  assign kid_in      = kid < bhtq_pkg::KID_W'(count);
  assign pick_right  = (kid_plus < bhtq_pkg::KID_W'(count)) && (rd_b.expiry < rd_a.expiry);
  assign child       = pick_right ? rd_b : rd_a;
  assign child_idx   = pick_right ? kid_plus[bhtq_pkg::IDX_W-1:0] : kid[bhtq_pkg::IDX_W-1:0];
  assign child_gt    = child.expiry > te.expiry;
  assign pop_now     = (count != '0) && (root_ent.expiry <= now_r);
  assign count_dec   = count - 1'b1;

  // Follow the root: look up the identifier being written there, else the held one
  assign cxl_raddr = (wr_en && wr_addr == '0) ? wr_data.ident[bhtq_pkg::ID_W-1:0]
                                               : root_ent.ident[bhtq_pkg::ID_W-1:0];

  // Cancel bit writes: clearing pass, add to a non-full heap clears, cancel sets
  always_comb begin
    cxl_we    = 1'b0;
    cxl_waddr = timer_id[bhtq_pkg::ID_W-1:0];
    cxl_wdata = 1'b0;
    if (state == ST_CLEAR) begin
      cxl_we    = 1'b1;
      cxl_waddr = clr_idx;
    end else if (accept && mode == bhtq_pkg::MODE_CANCEL) begin
      cxl_we    = 1'b1;
      cxl_wdata = 1'b1;
    end else if (accept && mode == bhtq_pkg::MODE_ADD &&
                 count < bhtq_pkg::CNT_W'(bhtq_pkg::CAPACITY)) begin
      cxl_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cxl_we) begin
      cancel_mem[cxl_waddr] <= cxl_wdata;
    end
    root_cancelled <= cancel_mem[cxl_raddr];
  end

  // Sequencer and heap RAM control
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = hole;
    wr_data    = new_ent;
    rd_addr_a  = parent;
    rd_addr_b  = kid_plus[bhtq_pkg::IDX_W-1:0];
    case (state)
      ST_CLEAR: begin
        if (clr_idx == bhtq_pkg::ID_W'(bhtq_pkg::ID_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (mode == bhtq_pkg::MODE_ADD && count < bhtq_pkg::CNT_W'(bhtq_pkg::CAPACITY)) begin
            state_next = ST_UP_RD;
          end else if (mode == bhtq_pkg::MODE_TICK) begin
            state_next = ST_TK_CHK;
          end
        end
      end
      ST_UP_RD: begin
        if (hole == '0) begin
          wr_en      = 1'b1;
          state_next = ST_RESP;
        end else begin
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a.expiry <= new_ent.expiry) begin
          state_next = ST_RESP;
        end else begin
          wr_data    = rd_a;
          state_next = ST_UP_RD;
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      ST_TK_CHK: begin
        rd_addr_a = count_dec[bhtq_pkg::IDX_W-1:0];
        if (!pop_now) begin
          state_next = ST_IDLE;
        end else if (count_dec != '0) begin
          state_next = ST_DN_LAST;
        end
      end
      ST_DN_LAST: begin
        state_next = ST_DN_RD;
      end
      ST_DN_RD: begin
        rd_addr_a = kid[bhtq_pkg::IDX_W-1:0];
        if (kid_in) begin
          state_next = ST_DN_CMP;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = pos;
          wr_data    = te;
          state_next = ST_TK_CHK;
        end
      end
      ST_DN_CMP: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        if (child_gt) begin
          wr_data    = te;
          state_next = ST_TK_CHK;
        end else begin
          wr_data    = child;
          state_next = ST_DN_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      count   <= '0;
      clr_idx <= '0;
      valid   <= 1'b0;
    end else begin
      state <= state_next;
      valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              bhtq_pkg::MODE_ADD: begin
                if (count < bhtq_pkg::CNT_W'(bhtq_pkg::CAPACITY)) begin
                  count <= count + 1'b1;
                end else begin
                  valid <= 1'b1;
                end
              end
              bhtq_pkg::MODE_CANCEL: begin
                valid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_RESP: begin
          valid <= 1'b1;
        end
        ST_TK_CHK: begin
          if (!pop_now) begin
            valid <= 1'b1;
          end else begin
            count <= count_dec;
            valid <= !root_cancelled;
          end
        end
        ST_DN_CMP: begin
          if (!child_gt) begin
            pos <= child_idx;
            kid <= bhtq_pkg::KID_W'({child_idx, 1'b1});
          end
        end
        default: ;
      endcase

      if (state == ST_IDLE && accept) begin
        new_ent.expiry <= expire_time;
        new_ent.ident  <= timer_id;
        now_r          <= now_time;
        hole           <= count[bhtq_pkg::IDX_W-1:0];
      end
      if (state == ST_UP_CMP) begin
        hole <= parent;
      end
      // Moved-up last entry starts sifting at the root
      if (state == ST_DN_LAST) begin
        te  <= rd_a;
        pos <= '0;
        kid <= bhtq_pkg::KID_W'(1);
      end
    end
  end

  // Shadow of the root for tick checks and result fields
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      root_ent <= wr_data;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        fired_id     <= timer_id;
        fired_expire <= root_expiry;
        entry_count  <= count;
        last         <= 1'b1;
        kind         <= (mode == bhtq_pkg::MODE_CANCEL) ? bhtq_pkg::KIND_CANCELLED
                                                        : bhtq_pkg::KIND_REJECTED;
      end
      ST_RESP: begin
        fired_id     <= new_ent.ident;
        fired_expire <= root_expiry;
        entry_count  <= count;
        last         <= 1'b1;
        kind         <= bhtq_pkg::KIND_ADDED;
      end
      ST_TK_CHK: begin
        if (pop_now) begin
          fired_id     <= root_ent.ident;
          fired_expire <= root_ent.expiry;
          entry_count  <= count_dec;
          last         <= 1'b0;
          kind         <= bhtq_pkg::KIND_FIRED;
        end else begin
          fired_id     <= '0;
          fired_expire <= root_expiry;
          entry_count  <= count;
          last         <= 1'b1;
          kind         <= bhtq_pkg::KIND_TICK_DONE;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/bhtq_checker.sv
// Port-level checks on the timer queue core, bound to its top level.
// Depends on bhtq_pkg for result codes and capacity.
module bhtq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  mode,
  input logic                        valid,
  input logic [2:0]                  kind,
  input logic [bhtq_pkg::CNT_W-1:0]  entry_count,
  input logic                        last
);

  // Final result of a request leaves the core ready
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy)
    else $error("final result while still busy");

  // Only fired results come mid-request, and the core stays busy
  a_mid_fired: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy && kind == bhtq_pkg::KIND_FIRED)
    else $error("non-final result is not a fired timer");

  a_cancel_resp: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == bhtq_pkg::MODE_CANCEL |=>
      valid && last && kind == bhtq_pkg::KIND_CANCELLED)
    else $error("cancel request without its result");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    valid && kind == bhtq_pkg::KIND_REJECTED |->
      entry_count == bhtq_pkg::CNT_W'(bhtq_pkg::CAPACITY))
    else $error("add rejected with heap not full");

endmodule

bind binary_heap_timer_queue_core bhtq_checker u_bhtq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .mode        (mode),
  .valid       (valid),
  .kind        (kind),
  .entry_count (entry_count),
  .last        (last)
);

### tb/binary_heap_timer_queue_core_tb.sv
`timescale 1ns / 100ps

// Self-checking testbench for binary_heap_timer_queue_core: directed and random
// add, cancel and tick requests, checked against an in-bench min-heap predictor.
// Depends on bhtq_pkg and the core RTL.

module binary_heap_timer_queue_core_tb;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    bhtq_pkg::kind_t                kind;
    logic [bhtq_pkg::TID_W-1:0]     id;
    logic [bhtq_pkg::TIME_BITS-1:0] expiry;
    logic [bhtq_pkg::CNT_W-1:0]     count;
    logic                           last;
  } timer_result_t;

  class timer_queue_scoreboard;
    logic [bhtq_pkg::TIME_BITS-1:0] slot_time [bhtq_pkg::CAPACITY];
    logic [bhtq_pkg::TID_W-1:0]     slot_id [bhtq_pkg::CAPACITY];
    bit                             dead [bhtq_pkg::ID_COUNT];
    int                             fill;
    timer_result_t                  pending [$];
    timer_result_t                  fresh [$];
    int                             errors;
    int                             checked;
    int                             fired;
    int                             rejected;
    int                             requests;
    int                             widest;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      fired = 0;
      rejected = 0;
      requests = 0;
      widest = 0;
      foreach (dead[i]) dead[i] = 1'b0;
    endfunction

    function logic [bhtq_pkg::TIME_BITS-1:0] root_time();
      return (fill > 0) ? slot_time[0] : '0;
    endfunction

    function void stage(bhtq_pkg::kind_t k, logic [bhtq_pkg::TID_W-1:0] id,
                        logic [bhtq_pkg::TIME_BITS-1:0] ex);
      timer_result_t r;
      r.kind   = k;
      r.id     = id;
      r.expiry = ex;
      r.count  = bhtq_pkg::CNT_W'(fill);
      r.last   = 1'b0;
      fresh.push_back(r);
    endfunction

    // Walk the hole up, stopping at a parent that is not later.
    function void sift_up(logic [bhtq_pkg::TIME_BITS-1:0] ex,
                          logic [bhtq_pkg::TID_W-1:0] id);
      int hole;
      int up;
      hole = fill;
      fill++;
      while (hole > 0) begin
        up = (hole - 1) / 2;
        if (slot_time[up] <= ex) break;
        slot_time[hole] = slot_time[up];
        slot_id[hole]   = slot_id[up];
        hole = up;
      end
      slot_time[hole] = ex;
      slot_id[hole]   = id;
    endfunction

    // Move the tail entry to the root and walk it down; right child only if
    // strictly earlier, stop when the child is later.
    function void pop_root();
      int                             pos;
      int                             kid;
      logic [bhtq_pkg::TIME_BITS-1:0] tail_time;
      logic [bhtq_pkg::TID_W-1:0]     tail_id;
      pos = 0;
      kid = 1;
      fill--;
      tail_time = slot_time[fill];
      tail_id   = slot_id[fill];
      while (kid < fill) begin
        if (kid + 1 < fill && slot_time[kid+1] < slot_time[kid]) kid++;
        if (slot_time[kid] > tail_time) break;
        slot_time[pos] = slot_time[kid];
        slot_id[pos]   = slot_id[kid];
        pos = kid;
        kid = pos * 2 + 1;
      end
      slot_time[pos] = tail_time;
      slot_id[pos]   = tail_id;
    endfunction

    function void note_request(logic [1:0] m, logic [bhtq_pkg::TID_W-1:0] id,
                               logic [bhtq_pkg::TIME_BITS-1:0] ex,
                               logic [bhtq_pkg::TIME_BITS-1:0] now);
      logic [bhtq_pkg::TIME_BITS-1:0] top_time;
      logic [bhtq_pkg::TID_W-1:0]     top_id;
      requests++;
      fresh.delete();
      case (m)
        bhtq_pkg::MODE_ADD: begin
          if (fill >= bhtq_pkg::CAPACITY) begin
            stage(bhtq_pkg::KIND_REJECTED, id, root_time());
          end else begin
            dead[int'(id) % bhtq_pkg::ID_COUNT] = 1'b0;
            sift_up(ex, id);
            stage(bhtq_pkg::KIND_ADDED, id, root_time());
          end
        end
        bhtq_pkg::MODE_CANCEL: begin
          dead[int'(id) % bhtq_pkg::ID_COUNT] = 1'b1;
          stage(bhtq_pkg::KIND_CANCELLED, id, root_time());
        end
        bhtq_pkg::MODE_TICK: begin
          while (fill > 0 && slot_time[0] <= now) begin
            top_time = slot_time[0];
            top_id   = slot_id[0];
            pop_root();
            // drop cancelled timers silently
            if (!dead[int'(top_id) % bhtq_pkg::ID_COUNT])
              stage(bhtq_pkg::KIND_FIRED, top_id, top_time);
          end
          stage(bhtq_pkg::KIND_TICK_DONE, '0, root_time());
        end
        default: return;
      endcase
      fresh[fresh.size()-1].last = 1'b1;
      if (fresh.size() > widest) widest = fresh.size();
      foreach (fresh[i]) pending.push_back(fresh[i]);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_result(logic [2:0] k, logic [bhtq_pkg::TID_W-1:0] id,
                      logic [bhtq_pkg::TIME_BITS-1:0] ex,
                      logic [bhtq_pkg::CNT_W-1:0] cnt, logic lst);
      timer_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result kind %0d id %0d with nothing pending", k, id));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.kind == bhtq_pkg::KIND_FIRED) fired++;
      if (want.kind == bhtq_pkg::KIND_REJECTED) rejected++;
      if (k != want.kind)
        report_mismatch($sformatf("kind got %0d want %0d", k, want.kind));
      if (id != want.id)
        report_mismatch($sformatf("fired_id got %0d want %0d", id, want.id));
      if (ex != want.expiry)
        report_mismatch($sformatf("fired_expire got %h want %h", ex, want.expiry));
      if (cnt != want.count)
        report_mismatch($sformatf("entry_count got %0d want %0d", cnt, want.count));
      if (lst != want.last)
        report_mismatch($sformatf("last got %0b want %0b", lst, want.last));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic [1:0]                     mode = '0;
  logic [bhtq_pkg::TID_W-1:0]     timer_id = '0;
  logic [bhtq_pkg::TIME_BITS-1:0] expire_time = '0;
  logic [bhtq_pkg::TIME_BITS-1:0] now_time = '0;
  logic                           busy;
  logic                           valid;
  logic [2:0]                     kind;
  logic [bhtq_pkg::TID_W-1:0]     fired_id;
  logic [bhtq_pkg::TIME_BITS-1:0] fired_expire;
  logic [bhtq_pkg::CNT_W-1:0]     entry_count;
  logic                           last;

  timer_queue_scoreboard          sb;
  int                             idle_pct = 0;
  int                             stall_cycles = 0;
  logic [bhtq_pkg::TIME_BITS-1:0] cur_time = '0;

  binary_heap_timer_queue_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .timer_id     (timer_id),
    .expire_time  (expire_time),
    .now_time     (now_time),
    .valid        (valid),
    .kind         (kind),
    .fired_id     (fired_id),
    .fired_expire (fired_expire),
    .entry_count  (entry_count),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && valid) sb.check_result(kind, fired_id, fired_expire, entry_count, last);
  end

  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("binary_heap_timer_queue_core test failed");
      $finish;
    end
  end

  // Optionally idle, then hold the request until the core takes it.
  task automatic send_request(input logic [1:0] m, input logic [bhtq_pkg::TID_W-1:0] id,
                              input logic [bhtq_pkg::TIME_BITS-1:0] ex,
                              input logic [bhtq_pkg::TIME_BITS-1:0] now);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    timer_id    <= id;
    expire_time <= ex;
    now_time    <= now;
    do @(posedge clk); while (busy);
    sb.note_request(m, id, ex, now);
  endtask

  task automatic random_item();
    int                             pick;
    logic [bhtq_pkg::TID_W-1:0]     id;
    logic [bhtq_pkg::TIME_BITS-1:0] ex;
    logic [bhtq_pkg::TIME_BITS-1:0] now;
    pick = $urandom_range(0, 99);
    // favor a small id pool so cancels and reuse hit live timers
    id  = ($urandom_range(0, 99) < 60) ? bhtq_pkg::TID_W'($urandom_range(0, 15))
                                        : bhtq_pkg::TID_W'($urandom_range(0, 255));
    ex  = $urandom;
    now = $urandom;
    if (pick < 50) begin
      if ($urandom_range(0, 99) >= 15) ex = cur_time + $urandom_range(0, 300);
      send_request(bhtq_pkg::MODE_ADD, id, ex, now);
    end else if (pick < 65) begin
      send_request(bhtq_pkg::MODE_CANCEL, id, ex, now);
    end else if (pick < 95) begin
      cur_time = cur_time + $urandom_range(0, 120);
      if ($urandom_range(0, 99) >= 8) now = cur_time;
      send_request(bhtq_pkg::MODE_TICK, id, ex, now);
    end else begin
      send_request(MODE_NONE, id, ex, now);
    end
  endtask

  // Fill to capacity with close expiries, overflow twice, then drain all.
  task automatic fill_heap(input int cancel_pct);
    logic [bhtq_pkg::TIME_BITS-1:0] base;
    base = cur_time;
    while (sb.fill < bhtq_pkg::CAPACITY) begin
      if ($urandom_range(0, 99) < cancel_pct)
        send_request(bhtq_pkg::MODE_CANCEL, bhtq_pkg::TID_W'($urandom_range(0, 255)),
                     $urandom, $urandom);
      send_request(bhtq_pkg::MODE_ADD, bhtq_pkg::TID_W'($urandom_range(0, 255)),
                   base + $urandom_range(0, 40), $urandom);
    end
    repeat (2) send_request(bhtq_pkg::MODE_ADD, bhtq_pkg::TID_W'($urandom_range(0, 255)),
                            $urandom, $urandom);
    send_request(bhtq_pkg::MODE_TICK, bhtq_pkg::TID_W'($urandom_range(0, 255)),
                 $urandom, '1);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    cur_time = $urandom;

    // directed: empty tick, absent cancel, extremes, equal keys, id reuse
    send_request(bhtq_pkg::MODE_TICK, 8'd0, $urandom, 32'd0);
    send_request(bhtq_pkg::MODE_CANCEL, 8'd200, $urandom, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd0, 32'hFFFF_FFFF, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd255, 32'd0, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd7, 32'd100, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd8, 32'd100, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd9, 32'd50, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd200, 32'd60, $urandom);
    send_request(bhtq_pkg::MODE_CANCEL, 8'd7, $urandom, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd3, 32'd10, $urandom);
    send_request(bhtq_pkg::MODE_CANCEL, 8'd3, $urandom, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd3, 32'd20, $urandom);
    send_request(bhtq_pkg::MODE_TICK, 8'd0, $urandom, 32'd99);
    send_request(bhtq_pkg::MODE_TICK, 8'd0, $urandom, 32'd100);
    send_request(MODE_NONE, 8'd0, $urandom, $urandom);
    send_request(bhtq_pkg::MODE_CANCEL, 8'd255, $urandom, $urandom);
    send_request(bhtq_pkg::MODE_ADD, 8'd128, 32'h8000_0000, $urandom);
    send_request(bhtq_pkg::MODE_TICK, 8'd0, $urandom, 32'h7FFF_FFFF);
    send_request(bhtq_pkg::MODE_TICK, 8'd0, $urandom, 32'hFFFF_FFFF);
    send_request(bhtq_pkg::MODE_TICK, 8'd0, $urandom, 32'hFFFF_FFFF);

    idle_pct = 0;
    fill_heap(0);
    repeat (5) random_item();
    idle_pct = 48;
    repeat (30) random_item();
    idle_pct = 6;
    fill_heap(25);
    repeat (5) random_item();

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d results checked, %0d timers fired, %0d adds rejected",
             sb.requests, sb.checked, sb.fired, sb.rejected);
    $display("largest single request output: %0d results, %0d mismatches",
             sb.widest, sb.errors);
    if (sb.errors == 0) begin
      $display("binary_heap_timer_queue_core test passed");
    end else begin
      $display("binary_heap_timer_queue_core test failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/bhtq_pkg.sv
rtl/bhtq_heap_ram.sv
rtl/binary_heap_timer_queue_core.sv
rtl/bhtq_checker.sv
tb/binary_heap_timer_queue_core_tb.sv
